### design/lirs_pkg.sv
// ============================================================================
// lirs_pkg
// Shared types and constants of the linear interpolation audio resampler.
// ============================================================================
`default_nettype none

package lirs_pkg;

    // Output sample rate, source rate after reset and minimum source rate, in Hz
    localparam int unsigned OUT_RATE    = 37500;
    localparam int unsigned RESET_RATE  = 44100;
    localparam int unsigned MIN_RATE    = 8000;

    // Q16 phase step after reset: floor(44100 * 65536 / 37500)
    localparam logic [16:0] RESET_STEP =
        17'((longint'(RESET_RATE) << 16) / longint'(OUT_RATE));

    // Reciprocal for the step: ceil(2^46 / OUT_RATE); step = (rate * STEP_RECIP) >> 30,
    // exact for every 16-bit rate
    localparam logic [30:0] STEP_RECIP =
        31'(((longint'(1) << 46) + longint'(OUT_RATE) - 64'sd1) / longint'(OUT_RATE));

    // Q15 gain after reset
    localparam logic [14:0] GAIN_RESET  = 15'd16384;

    // Results per source item are bounded by the minimum rate
    localparam int unsigned MAX_RESULTS = 5;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_GAIN_LEFT  = 1'b0,
        CFG_GAIN_RIGHT = 1'b1
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIVH,
        ST_CHECK,
        ST_MDL,
        ST_AL,
        ST_MGL,
        ST_MDR,
        ST_AR,
        ST_MGR,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

### design/lirs_in_if.sv
// ============================================================================
// lirs_in_if
// Source item channel: valid/ready handshake with the source sample payload.
// ============================================================================
`default_nettype none

interface lirs_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic               stereo;
    logic        [15:0] source_rate;
    logic               end_of_frame;

    modport source (
        output valid, mode, sample_left, sample_right, stereo, source_rate, end_of_frame,
        input  ready
    );

    modport sink (
        input  valid, mode, sample_left, sample_right, stereo, source_rate, end_of_frame,
        output ready
    );
endinterface

`default_nettype wire

### design/lirs_out_if.sv
// ============================================================================
// lirs_out_if
// Result item channel: valid/ready handshake with one stereo output pair.
// ============================================================================
`default_nettype none

interface lirs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               frame_done;
    logic               last;

    modport source (
        output valid, out_left, out_right, frame_done, last,
        input  ready
    );

    modport sink (
        input  valid, out_left, out_right, frame_done, last,
        output ready
    );
endinterface

`default_nettype wire

### design/linear_interp_audio_resampler.sv
// ============================================================================
// linear_interp_audio_resampler
// Converts source samples to 37500 Hz stereo pairs by linear interpolation
// with a Q16 phase accumulator, then applies a Q15 gain per channel.
// ============================================================================
//
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      mode, sample_left/right, stereo,
//                                    source_rate, end_of_frame
//  o_out     out  valid / ready      out_left, out_right, frame_done, last
//  i_cfg_*   in   write enable only  gain_left (0), gain_right (1)
//
//  One item is worked at a time; ready is high only while the sequencer idles.
//  An item yields n output pairs (n = 0..5) and a flush yields none; a source
//  rate change adds the DIV and DIVH states (step from a reciprocal product).
//  All step, interpolation and gain products share one 17x17 signed multiplier.
//  A held result sits in the output register; a stall there holds the
//  sequencer in its emit state. Reset is synchronous.
// ============================================================================
`default_nettype none

module linear_interp_audio_resampler (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    lirs_in_if.sink                   i_in,
    lirs_out_if.source                o_out,
    input  wire logic                 i_cfg_we,
    input  wire lirs_pkg::t_cfg_idx   i_cfg_idx,
    input  wire logic [14:0]          i_cfg_data
);
    import lirs_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;

    logic [14:0]         r_gain_l, r_gain_r;
    logic [17:0]         r_phase;
    logic [15:0]         r_rate;
    logic [16:0]         r_step;
    logic signed [15:0]  r_prev_l, r_prev_r;

    logic signed [15:0]  r_cur_l, r_cur_r;
    logic                r_eof;
    logic [2:0]          r_n;

    logic [15:0]         r_eff_rate;

    logic signed [32:0]  r_prod;
    logic signed [15:0]  r_val;
    logic signed [15:0]  r_res_l;

    logic                r_out_valid;
    logic signed [15:0]  r_out_l, r_out_r;
    logic                r_out_fd, r_out_last;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                w_in_fire;
    logic                w_emit;
    logic                w_more;
    logic                w_last;
    logic [17:0]         w_phase_next;
    logic [15:0]         w_eff_rate;
    logic [31:0]         w_step_sum;
    logic signed [16:0]  w_mul_a, w_mul_b;
    logic signed [33:0]  w_mul_p;
    logic signed [15:0]  w_prev_sel;
    logic signed [16:0]  w_sum;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_fire   = i_in.valid && (r_state == ST_IDLE);

    assign o_out.valid      = r_out_valid;
    assign o_out.out_left   = r_out_l;
    assign o_out.out_right  = r_out_r;
    assign o_out.frame_done = r_out_fd;
    assign o_out.last       = r_out_last;

    // Phase walk
    assign w_phase_next = r_phase + {1'b0, r_step};
    assign w_more = (r_phase[17:16] == 2'b00) && (r_n != 3'(MAX_RESULTS));
    assign w_last = (w_phase_next[17:16] != 2'b00) || (r_n == 3'(MAX_RESULTS - 1));

    // Rates under the minimum count as the minimum for the step
    assign w_eff_rate = (i_in.source_rate < 16'(MIN_RATE)) ? 16'(MIN_RATE)
                                                           : i_in.source_rate;

    // Shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_DIV: begin
                w_mul_a = $signed({1'b0, r_eff_rate});
                w_mul_b = $signed({1'b0, STEP_RECIP[15:0]});
            end
            ST_DIVH: begin
                w_mul_a = $signed({1'b0, r_eff_rate});
                w_mul_b = $signed({2'b00, STEP_RECIP[30:16]});
            end
            ST_MDL: begin
                w_mul_a = 17'(r_cur_l) - 17'(r_prev_l);
                w_mul_b = $signed({1'b0, r_phase[15:0]});
            end
            ST_MGL: begin
                w_mul_a = 17'(r_val);
                w_mul_b = $signed({2'b00, r_gain_l});
            end
            ST_MDR: begin
                w_mul_a = 17'(r_cur_r) - 17'(r_prev_r);
                w_mul_b = $signed({1'b0, r_phase[15:0]});
            end
            ST_MGR: begin
                w_mul_a = 17'(r_val);
                w_mul_b = $signed({2'b00, r_gain_r});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // Step = (rate * recip) >> 30, from high partial product plus low one >> 16
    assign w_step_sum = w_mul_p[31:0] + {16'b0, r_prod[31:16]};

    // prev + floor(diff * frac / 65536); stays within 16 bits
    assign w_prev_sel = (r_state == ST_AR) ? r_prev_r : r_prev_l;
    assign w_sum      = 17'(w_prev_sel) + $signed(r_prod[32:16]);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_emit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire && !i_in.mode) begin
                    n_state = (i_in.source_rate != r_rate) ? ST_DIV : ST_CHECK;
                end
            end
            ST_DIV:   n_state = ST_DIVH;
            ST_DIVH:  n_state = ST_CHECK;
            ST_CHECK: n_state = w_more ? ST_MDL : ST_IDLE;
            ST_MDL:   n_state = ST_AL;
            ST_AL:    n_state = ST_MGL;
            ST_MGL:   n_state = ST_MDR;
            ST_MDR:   n_state = ST_AR;
            ST_AR:    n_state = ST_MGR;
            ST_MGR:   n_state = ST_EMIT;
            ST_EMIT: begin
                w_emit = !r_out_valid || o_out.ready;
                if (w_emit) begin
                    n_state = ST_CHECK;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_l    <= GAIN_RESET;
            r_gain_r    <= GAIN_RESET;
            r_phase     <= '0;
            r_rate      <= 16'(RESET_RATE);
            r_step      <= RESET_STEP;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAIN_LEFT:  r_gain_l <= i_cfg_data;
                    CFG_GAIN_RIGHT: r_gain_r <= i_cfg_data;
                    default: ;
                endcase
            end

            // Output register loads on emit, drains on handshake
            if (r_state == ST_EMIT && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        if (i_in.mode) begin
                            // flush: phase and held pair to zero
                            r_phase  <= '0;
                            r_prev_l <= '0;
                            r_prev_r <= '0;
                        end else begin
                            r_cur_l <= i_in.sample_left;
                            r_cur_r <= i_in.stereo ? i_in.sample_right : i_in.sample_left;
                            r_eof   <= i_in.end_of_frame;
                            r_n     <= '0;
                            // rate change restarts phase and recomputes the step
                            if (i_in.source_rate != r_rate) begin
                                r_rate     <= i_in.source_rate;
                                r_phase    <= '0;
                                r_eff_rate <= w_eff_rate;
                            end
                        end
                    end
                end
                ST_DIV:  r_prod <= w_mul_p[32:0];
                ST_DIVH: r_step <= w_step_sum[30:14];
                ST_CHECK: begin
                    // end of this item's run: drop one sample, hold current pair
                    if (!w_more) begin
                        if (r_phase[17:16] != 2'b00) begin
                            r_phase <= r_phase - 18'h10000;
                        end
                        r_prev_l <= r_cur_l;
                        r_prev_r <= r_cur_r;
                    end
                end
                ST_MDL: r_prod <= w_mul_p[32:0];
                ST_AL:  r_val  <= w_sum[15:0];
                ST_MGL: r_prod <= w_mul_p[32:0];
                ST_MDR: begin
                    r_res_l <= r_prod[30:15];
                    r_prod  <= w_mul_p[32:0];
                end
                ST_AR:  r_val  <= w_sum[15:0];
                ST_MGR: r_prod <= w_mul_p[32:0];
                ST_EMIT: begin
                    if (w_emit) begin
                        r_out_l     <= r_res_l;
                        r_out_r     <= r_prod[30:15];
                        r_out_last  <= w_last;
                        r_out_fd    <= w_last && r_eof;
                        r_phase     <= w_phase_next;
                        r_n         <= r_n + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 3'(MAX_RESULTS))
        else $error("result count past bound");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_phase[17] == 1'b0))
        else $error("phase out of range between items");

    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == ST_EMIT))
        else $error("output loaded outside emit");

    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVH)
            |=> (r_step >= 17'(((MIN_RATE) * 65536) / OUT_RATE)))
        else $error("phase step below minimum");

endmodule

`default_nettype wire

### sim/tb_linear_interp_audio_resampler.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_linear_interp_audio_resampler
// Self-checking bench for the 37500 Hz linear interpolation resampler. A
// behavioral copy of the phase accumulator, held pair and gain stage predicts
// every output pair. The bench runs directed cases for sample extremes, mono,
// rate limits, flush, frame marks and gain extremes, then random framed
// streams under several gain settings. Random stalls on both channels.
// ============================================================================

module tb_linear_interp_audio_resampler;
    import lirs_pkg::*;

    // Cycles to let the sequencer settle after the last result of a phase
    localparam int DRAIN_CYCLES = 64;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int RANDOM_ITEMS = 80;

    typedef struct {
        logic               mode;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic               stereo;
        logic        [15:0] source_rate;
        logic               end_of_frame;
    } t_src_item;

    typedef struct {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
        logic               frame_done;
        logic               last;
    } t_pair;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [14:0] cfg_data;

    lirs_in_if  in_if ();
    lirs_out_if out_if ();

    // Predictor state: phase accumulator, rate, held pair and gains
    logic        [17:0] acc_phase;
    logic        [15:0] rate_now;
    logic signed [15:0] held_left;
    logic signed [15:0] held_right;
    logic        [14:0] gain_left_q15;
    logic        [14:0] gain_right_q15;

    t_pair expected_pairs[$];
    bit    idling_on;
    int    items_sent    = 0;
    int    flush_count   = 0;
    int    rate_changes  = 0;
    int    pairs_checked = 0;
    int    fail_count    = 0;

    // 250 MHz clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    linear_interp_audio_resampler DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Q16 step per output sample; slow rates are clamped to the minimum
    function automatic logic [16:0] step_for_rate(input logic [15:0] rate);
        longint eff;
        eff = rate;
        if (eff < longint'(MIN_RATE))
            eff = longint'(MIN_RATE);
        return 17'((eff << 16) / longint'(OUT_RATE));
    endfunction

    // a + floor((b - a) * frac / 2^16), then floor(v * gain / 2^15)
    function automatic logic signed [15:0] lerp_scale(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic        [15:0] frac,
        input logic        [14:0] gain
    );
        longint d;
        longint v;
        longint p;
        d = longint'(b) - longint'(a);
        v = longint'(a) + ((d * longint'(frac)) >>> 16);
        p = (v * longint'(gain)) >>> 15;
        return p[15:0];
    endfunction

    // Works out the output pairs of one accepted item and queues them
    task automatic interpolate_item(input t_src_item it);
        logic signed [15:0] cur_left;
        logic signed [15:0] cur_right;
        logic        [16:0] phase_inc;
        t_pair              pend;
        int                 n;
        if (it.mode) begin
            acc_phase  = '0;
            held_left  = '0;
            held_right = '0;
            flush_count++;
        end else begin
            if (it.source_rate != rate_now) begin
                rate_now  = it.source_rate;
                acc_phase = '0;
                rate_changes++;
            end
            phase_inc = step_for_rate(it.source_rate);
            cur_left  = it.sample_left;
            cur_right = it.stereo ? it.sample_right : it.sample_left;
            n = 0;
            // one pair per phase step that lands inside the held-to-current gap
            while (acc_phase[17:16] == 2'b00 && n < MAX_RESULTS) begin
                if (n > 0)
                    expected_pairs.push_back(pend);
                pend.out_left   = lerp_scale(held_left, cur_left, acc_phase[15:0],
                                             gain_left_q15);
                pend.out_right  = lerp_scale(held_right, cur_right, acc_phase[15:0],
                                             gain_right_q15);
                pend.frame_done = 1'b0;
                pend.last       = 1'b0;
                acc_phase = acc_phase + 18'(phase_inc);
                n++;
            end
            if (acc_phase[17:16] != 2'b00)
                acc_phase = acc_phase - 18'h10000;
            held_left  = cur_left;
            held_right = cur_right;
            if (n > 0) begin
                pend.frame_done = it.end_of_frame;
                pend.last       = 1'b1;
                expected_pairs.push_back(pend);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_src_item make_sample(
        input logic signed [15:0] left,
        input logic signed [15:0] right,
        input logic               st,
        input logic        [15:0] rate,
        input logic               eof
    );
        t_src_item it;
        it.mode         = 1'b0;
        it.sample_left  = left;
        it.sample_right = right;
        it.stereo       = st;
        it.source_rate  = rate;
        it.end_of_frame = eof;
        return it;
    endfunction

    // Mostly full-range noise, now and then a rail value
    function automatic logic signed [15:0] rand_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'sh7FFF;
        if (r == 1)
            return 16'sh8000;
        return 16'($urandom);
    endfunction

    // Flush with garbage in the fields it ignores
    function automatic t_src_item make_flush();
        t_src_item it;
        it = make_sample(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        it.mode = 1'b1;
        return it;
    endfunction

    // Common audio rates, some in-range randoms, rarely anything at all
    function automatic logic [15:0] pick_rate();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            case ($urandom_range(0, 8))
                0:       return 16'd8000;
                1:       return 16'd11025;
                2:       return 16'd12000;
                3:       return 16'd16000;
                4:       return 16'd22050;
                5:       return 16'd24000;
                6:       return 16'd32000;
                7:       return 16'd44100;
                default: return 16'd48000;
            endcase
        end
        if (r < 9)
            return 16'($urandom_range(8000, 48000));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Sends one item after an optional gap, then predicts it on acceptance
    task automatic send_item(input t_src_item it);
        int gap;
        int r;
        gap = 0;
        if (idling_on) begin
            r = $urandom_range(0, 99);
            if (r >= 90)
                gap = $urandom_range(8, 40);
            else if (r >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.mode         <= it.mode;
        in_if.sample_left  <= it.sample_left;
        in_if.sample_right <= it.sample_right;
        in_if.stereo       <= it.stereo;
        in_if.source_rate  <= it.source_rate;
        in_if.end_of_frame <= it.end_of_frame;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        items_sent++;
        interpolate_item(it);
    endtask

    // Drops valid, waits out every queued pair and the sequencer's tail
    task automatic wait_idle();
        int waited;
        waited = 0;
        in_if.valid <= 1'b0;
        while (expected_pairs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_pairs.size() != 0) begin
            $error("%0d expected output pairs never arrived", expected_pairs.size());
            fail_count++;
            expected_pairs.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gain(input t_cfg_idx idx, input logic [14:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_GAIN_LEFT:  gain_left_q15  = value;
            CFG_GAIN_RIGHT: gain_right_q15 = value;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // First pairs after reset: default rate, default gains, zero held pair
    task automatic test_reset_state();
        send_item(make_sample(16'sd1000, -16'sd1000, 1'b1, 16'(RESET_RATE), 1'b0));
        send_item(make_sample(16'sd2000, 16'sd500, 1'b1, 16'(RESET_RATE), 1'b1));
    endtask

    // Full-scale swings at the slowest rate, up to five pairs per item
    task automatic test_sample_extremes();
        send_item(make_sample(16'sh7FFF, 16'sh8000, 1'b1, 16'd8000, 1'b0));
        send_item(make_sample(16'sh8000, 16'sh7FFF, 1'b1, 16'd8000, 1'b0));
        send_item(make_sample(16'sh7FFF, 16'sh7FFF, 1'b1, 16'd8000, 1'b0));
        send_item(make_sample(16'sh8000, 16'sh8000, 1'b1, 16'd8000, 1'b1));
    endtask

    // Mono: right input must be ignored
    task automatic test_mono_mix();
        send_item(make_sample(-16'sd12345, 16'sh1234, 1'b0, 16'd22050, 1'b0));
        send_item(make_sample(16'sh7FFF, -16'sd1, 1'b0, 16'd22050, 1'b1));
    endtask

    // Rates below the clamp, at the edges, and fast enough to skip items
    task automatic test_rate_limits();
        send_item(make_sample(rand_sample(), rand_sample(), 1'b1, 16'd0, 1'b0));
        send_item(make_sample(rand_sample(), rand_sample(), 1'b1, 16'd7999, 1'b0));
        send_item(make_sample(rand_sample(), rand_sample(), 1'b1, 16'd8000, 1'b0));
        send_item(make_sample(rand_sample(), rand_sample(), 1'b1, 16'd48000, 1'b0));
        send_item(make_sample(rand_sample(), rand_sample(), 1'b1, 16'hFFFF, 1'b0));
        send_item(make_sample(rand_sample(), rand_sample(), 1'b0, 16'hFFFF, 1'b1));
    endtask

    // Flush mid-stream clears phase and held pair but keeps the rate
    task automatic test_flush();
        send_item(make_sample(16'sd20000, -16'sd20000, 1'b1, 16'd16000, 1'b0));
        send_item(make_flush());
        send_item(make_sample(-16'sd30000, 16'sd30000, 1'b1, 16'd16000, 1'b1));
    endtask

    // Frame marks, including on items that produce no pair
    task automatic test_frame_marks();
        send_item(make_sample(16'sd100, 16'sd200, 1'b1, 16'd65535, 1'b1));
        send_item(make_sample(16'sd300, 16'sd400, 1'b1, 16'd65535, 1'b1));
        send_item(make_sample(16'sd500, 16'sd600, 1'b1, 16'd65535, 1'b1));
        send_item(make_sample(16'sd700, 16'sd800, 1'b1, 16'd65535, 1'b1));
        send_item(make_sample(16'sd900, 16'sd1000, 1'b1, 16'd8000, 1'b1));
    endtask

    // Zero, full 15-bit and nominal gain on each channel
    task automatic test_gain_settings();
        wait_idle();
        write_gain(CFG_GAIN_LEFT, 15'd0);
        write_gain(CFG_GAIN_RIGHT, 15'h7FFF);
        send_item(make_sample(16'sh7FFF, 16'sh8000, 1'b1, 16'd12000, 1'b0));
        send_item(make_sample(16'sh8000, 16'sh7FFF, 1'b1, 16'd12000, 1'b0));
        wait_idle();
        write_gain(CFG_GAIN_LEFT, 15'h7FFF);
        write_gain(CFG_GAIN_RIGHT, 15'd0);
        send_item(make_sample(16'sh8000, 16'sh7FFF, 1'b1, 16'd12000, 1'b1));
        wait_idle();
        write_gain(CFG_GAIN_LEFT, GAIN_RESET);
        write_gain(CFG_GAIN_RIGHT, GAIN_RESET);
        send_item(make_sample(16'sh7FFF, 16'sh8000, 1'b1, 16'd12000, 1'b1));
    endtask

    // Framed streams with random content, plus flushes, noise and rate glitches
    task automatic test_random_streams(
        input int          n_items,
        input logic [14:0] gl,
        input logic [14:0] gr,
        input bit          idle
    );
        int          sent;
        int          frame_len;
        int          k;
        int          r;
        logic [15:0] rate;
        logic        st;
        t_src_item   it;
        wait_idle();
        write_gain(CFG_GAIN_LEFT, gl);
        write_gain(CFG_GAIN_RIGHT, gr);
        idling_on = idle;
        sent = 0;
        rate = pick_rate();
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_item(make_flush());
                sent++;
            end else if (r < 10) begin
                // stray item with any rate
                it = make_sample(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)),
                                 16'($urandom_range(0, 65535)),
                                 1'($urandom_range(0, 1)));
                send_item(it);
                sent++;
            end else begin
                // one frame; rate usually carries over from the last frame
                if ($urandom_range(0, 3) == 0)
                    rate = pick_rate();
                st = 1'($urandom_range(0, 1));
                frame_len = $urandom_range(3, 16);
                for (k = 0; k < frame_len; k++) begin
                    it = make_sample(rand_sample(), rand_sample(), st, rate,
                                     k == frame_len - 1);
                    if ($urandom_range(0, 49) == 0)
                        it.source_rate = pick_rate();
                    send_item(it);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random backpressure
    // ------------------------------------------------------------------------
    initial begin : sink_pacing
        int hold;
        int r;
        hold = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                out_if.ready <= 1'b0;
                hold--;
            end else begin
                out_if.ready <= 1'b1;
                if (idling_on) begin
                    r = $urandom_range(0, 99);
                    if (r < 17)
                        hold = $urandom_range(1, 3);
                    else if (r < 20)
                        hold = $urandom_range(8, 40);
                end
            end
        end
    end

    // Compare each accepted pair with the oldest expectation
    always @(posedge i_clk) begin : pair_check
        t_pair want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_pairs.size() == 0) begin
                $error("unexpected output pair: left %0d right %0d",
                       out_if.out_left, out_if.out_right);
                fail_count++;
            end else begin
                want = expected_pairs.pop_front();
                pairs_checked++;
                if (out_if.out_left !== want.out_left) begin
                    $error("out_left: expected %0d, got %0d", want.out_left,
                           out_if.out_left);
                    fail_count++;
                end
                if (out_if.out_right !== want.out_right) begin
                    $error("out_right: expected %0d, got %0d", want.out_right,
                           out_if.out_right);
                    fail_count++;
                end
                if (out_if.frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0b, got %0b", want.frame_done,
                           out_if.frame_done);
                    fail_count++;
                end
                if (out_if.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, out_if.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.mode         = 1'b0;
        in_if.sample_left  = '0;
        in_if.sample_right = '0;
        in_if.stereo       = 1'b0;
        in_if.source_rate  = 16'(RESET_RATE);
        in_if.end_of_frame = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_GAIN_LEFT;
        cfg_data           = '0;
        idling_on          = 1'b1;
        acc_phase          = '0;
        rate_now           = 16'(RESET_RATE);
        held_left          = '0;
        held_right         = '0;
        gain_left_q15      = GAIN_RESET;
        gain_right_q15     = GAIN_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_sample_extremes();
        test_mono_mix();
        test_rate_limits();
        test_flush();
        test_frame_marks();
        test_gain_settings();
        test_random_streams(RANDOM_ITEMS, GAIN_RESET, GAIN_RESET, 1'b1);
        test_random_streams(RANDOM_ITEMS, 15'($urandom), 15'($urandom), 1'b0);
        test_random_streams(RANDOM_ITEMS, 15'($urandom_range(0, 16384)),
                            15'($urandom_range(0, 16384)), 1'b1);
        test_random_streams(RANDOM_ITEMS, 15'h7FFF, 15'h4000, 1'b1);
        wait_idle();

        $display("Ran %0d source items (%0d flushes, %0d rate changes), checked %0d pairs",
                 items_sent, flush_count, rate_changes, pairs_checked);
        $display("Gains from zero to full 15-bit scale, rates 0 to 65535, stalls on/off");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $error("timeout: output pairs stopped arriving");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
